// ----- rtl/core/sgsi_pkg.sv -----
// ----------------------------------------------------------------------------
// sgsi_pkg
// Shared types, codes and helpers of the structured grid simplex indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package sgsi_pkg;

   localparam int unsigned MAX_DIVISIONS = 1024;
   localparam int unsigned DIV_W         = 11;
   localparam int unsigned CORNER_W      = 31;
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   // register indexes on the csr port
   localparam logic [2:0] REG_DIMENSION   = 3'd0;
   localparam logic [2:0] REG_DIVISIONS_X = 3'd1;
   localparam logic [2:0] REG_DIVISIONS_Y = 3'd2;
   localparam logic [2:0] REG_DIVISIONS_Z = 3'd3;
   localparam logic [2:0] REG_DIAMOND     = 3'd4;

   // dimension codes
   localparam logic [1:0] DIM_ONE   = 2'd1;
   localparam logic [1:0] DIM_TWO   = 2'd2;
   localparam logic [1:0] DIM_THREE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_DIAMOND = 2'd2;

   // vertex counts
   localparam logic [2:0] VC_NONE = 3'd0;
   localparam logic [2:0] VC_SEG  = 3'd2;
   localparam logic [2:0] VC_TRI  = 3'd3;
   localparam logic [2:0] VC_TET  = 3'd4;

   typedef enum logic [2:0] {
      MODE_ERR,
      MODE_SEG,
      MODE_TRI,
      MODE_FAN,
      MODE_TET
   } mode_type;

   typedef struct packed {
      logic [1:0]       dimension;
      logic [DIV_W-1:0] divisions_x;
      logic [DIV_W-1:0] divisions_y;
      logic [DIV_W-1:0] divisions_z;
      logic             diamond;
   } cfg_type;

   // one classified cell: base corners, the back end derives the rest
   typedef struct packed {
      logic [1:0]          status;
      mode_type            mode;
      logic [CORNER_W-1:0] a;
      logic [CORNER_W-1:0] c;
      logic [CORNER_W-1:0] e;
      logic [CORNER_W-1:0] g;
      logic [CORNER_W-1:0] ctr;
   } desc_type;

   function automatic logic [DIV_W-1:0] sat_div(input logic [DIV_W-1:0] v);
      logic [DIV_W-1:0] r;
      r = v;
      if (v > DIV_W'(MAX_DIVISIONS)) begin
         r = DIV_W'(MAX_DIVISIONS);
      end
      return r;
   endfunction

   // index of the final simplex of a cell
   function automatic logic [2:0] last_step(input mode_type mode);
      logic [2:0] r;
      unique case (mode)
         MODE_TRI: begin
            r = 3'd1;
         end
         MODE_FAN: begin
            r = 3'd3;
         end
         MODE_TET: begin
            r = 3'd5;
         end
         default: begin
            r = 3'd0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sgsi_front.sv -----
// ----------------------------------------------------------------------------
// sgsi_front
// Accepts cells, checks them against the grid and computes base vertex indices.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsi_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sgsi_pkg::cfg_type cfg,
   input  wire logic              in_push,
   output logic                   in_full,
   input  wire logic [10:0]       cell_x,
   input  wire logic [9:0]        cell_y,
   input  wire logic [9:0]        cell_z,
   output logic                   q_push,
   output sgsi_pkg::desc_type     q_data,
   input  wire logic              q_full
);
   import sgsi_pkg::*;

   logic stall;
   logic take;

   // stage 1: classification
   logic [DIV_W-1:0] m, n, p;
   logic [DIV_W:0]   cells;
   logic [1:0]       st_in;
   mode_type         md_in;
   logic             s1_valid_ff;
   logic [10:0]      s1_i_ff;
   logic [9:0]       s1_j_ff, s1_k_ff;
   logic [DIV_W-1:0] s1_row_ff, s1_m_ff, s1_np1_ff;
   logic [1:0]       s1_st_ff;
   mode_type         s1_md_ff;

   // stage 2: first products
   logic             s2_valid_ff;
   logic [10:0]      s2_i_ff;
   logic [9:0]       s2_k_ff;
   logic [20:0]      s2_jr_ff, s2_layer_ff, s2_jm_ff;
   logic [DIV_W-1:0] s2_row_ff;
   logic [1:0]       s2_st_ff;
   mode_type         s2_md_ff;

   // stage 3: depth product and partial sums
   logic               s3_valid_ff;
   logic [CORNER_W-1:0] s3_kl_ff;
   logic [21:0]        s3_aa_ff, s3_cc_ff;
   logic [20:0]        s3_layer_ff;
   logic [DIV_W-1:0]   s3_row_ff;
   logic [1:0]         s3_st_ff;
   mode_type           s3_md_ff;

   // stage 4: descriptor
   logic     s4_valid_ff;
   desc_type s4_desc_ff;
   logic [CORNER_W-1:0] base;

   assign stall   = s4_valid_ff && q_full;
   assign in_full = stall;
   assign take    = in_push && !stall;
   assign q_push  = s4_valid_ff && !q_full;
   assign q_data  = s4_desc_ff;

   assign m = sat_div(cfg.divisions_x);
   assign n = sat_div(cfg.divisions_y);
   assign p = sat_div(cfg.divisions_z);

   always_comb begin
      st_in = ST_OK;
      md_in = MODE_ERR;
      cells = {1'b0, m};
      if (cfg.diamond && (m != '0)) begin
         cells = {m, 1'b0} - (DIV_W+1)'(1);
      end else if (cfg.diamond) begin
         cells = '0;
      end
      unique case (cfg.dimension)
         DIM_ONE: begin
            if ({1'b0, cell_x} >= cells) begin
               st_in = ST_RANGE;
            end else begin
               md_in = MODE_SEG;
            end
         end
         DIM_TWO: begin
            if (cell_x >= m || {1'b0, cell_y} >= n) begin
               st_in = ST_RANGE;
            end else begin
               md_in = cfg.diamond ? MODE_FAN : MODE_TRI;
            end
         end
         DIM_THREE: begin
            if (cfg.diamond) begin
               st_in = ST_DIAMOND;
            end else if (cell_x >= m || {1'b0, cell_y} >= n || {1'b0, cell_z} >= p) begin
               st_in = ST_RANGE;
            end else begin
               md_in = MODE_TET;
            end
         end
         default: begin
            st_in = ST_RANGE;
         end
      endcase
   end

   assign base = s3_kl_ff + CORNER_W'(s3_aa_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= in_push;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_i_ff   <= cell_x;
         s1_j_ff   <= (md_in == MODE_TRI || md_in == MODE_FAN || md_in == MODE_TET)
                      ? cell_y : '0;
         s1_k_ff   <= (md_in == MODE_TET) ? cell_z : '0;
         s1_row_ff <= m + DIV_W'(1);
         s1_m_ff   <= m;
         s1_np1_ff <= n + DIV_W'(1);
         s1_st_ff  <= st_in;
         s1_md_ff  <= md_in;
      end
      if (!stall) begin
         s2_i_ff     <= s1_i_ff;
         s2_k_ff     <= s1_k_ff;
         s2_jr_ff    <= 21'(s1_j_ff) * 21'(s1_row_ff);
         s2_layer_ff <= 21'(s1_row_ff) * 21'(s1_np1_ff);
         s2_jm_ff    <= 21'(s1_j_ff) * 21'(s1_m_ff);
         s2_row_ff   <= s1_row_ff;
         s2_st_ff    <= s1_st_ff;
         s2_md_ff    <= s1_md_ff;

         s3_kl_ff    <= CORNER_W'(s2_k_ff) * CORNER_W'(s2_layer_ff);
         s3_aa_ff    <= 22'(s2_jr_ff) + 22'(s2_i_ff);
         s3_cc_ff    <= 22'(s2_layer_ff) + 22'(s2_jm_ff) + 22'(s2_i_ff);
         s3_layer_ff <= s2_layer_ff;
         s3_row_ff   <= s2_row_ff;
         s3_st_ff    <= s2_st_ff;
         s3_md_ff    <= s2_md_ff;

         s4_desc_ff.status <= s3_st_ff;
         s4_desc_ff.mode   <= s3_md_ff;
         s4_desc_ff.a      <= base;
         s4_desc_ff.c      <= base + CORNER_W'(s3_row_ff);
         s4_desc_ff.e      <= base + CORNER_W'(s3_layer_ff);
         s4_desc_ff.g      <= base + CORNER_W'(s3_layer_ff) + CORNER_W'(s3_row_ff);
         s4_desc_ff.ctr    <= CORNER_W'(s3_cc_ff);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sgsi_queue.sv -----
// ----------------------------------------------------------------------------
// sgsi_queue
// Short queue of classified cells between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsi_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sgsi_pkg::desc_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output sgsi_pkg::desc_type      pop_data,
   output logic                    empty
);
   import sgsi_pkg::*;

   desc_type               mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QUEUE_PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sgsi_back.sv -----
// ----------------------------------------------------------------------------
// sgsi_back
// Walks a cell's simplices into the result register, one per cycle while drained.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsi_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sgsi_pkg::desc_type q_data,
   input  wire logic               q_empty,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [1:0]              rsp_status,
   output logic [2:0]              rsp_vertex_count,
   output logic [30:0]             rsp_corner_zero,
   output logic [30:0]             rsp_corner_one,
   output logic [30:0]             rsp_corner_two,
   output logic [30:0]             rsp_corner_three,
   output logic                    rsp_last
);
   import sgsi_pkg::*;

   desc_type cur_ff;
   logic     busy_ff;
   logic [2:0] step_ff;
   logic     out_valid_ff;
   logic     adv, fire, done;

   logic [CORNER_W-1:0] a, b, c, d, e, f, g, h, ctr;
   logic [CORNER_W-1:0] v0, v1, v2, v3;
   logic [2:0]          vc;
   logic                lst;

   assign adv   = !out_valid_ff || rsp_pop;
   assign fire  = busy_ff && adv;
   assign lst   = (step_ff == last_step(cur_ff.mode));
   assign done  = fire && lst;
   assign q_pop = (!busy_ff || done) && !q_empty;

   assign rsp_empty = !out_valid_ff;

   assign a   = cur_ff.a;
   assign b   = cur_ff.a + CORNER_W'(1);
   assign c   = cur_ff.c;
   assign d   = cur_ff.c + CORNER_W'(1);
   assign e   = cur_ff.e;
   assign f   = cur_ff.e + CORNER_W'(1);
   assign g   = cur_ff.g;
   assign h   = cur_ff.g + CORNER_W'(1);
   assign ctr = cur_ff.ctr;

   always_comb begin
      v0 = '0;
      v1 = '0;
      v2 = '0;
      v3 = '0;
      vc = VC_NONE;
      unique case (cur_ff.mode)
         MODE_SEG: begin
            vc = VC_SEG;
            v0 = a;
            v1 = b;
         end
         MODE_TRI: begin
            vc = VC_TRI;
            if (step_ff == 3'd0) begin
               v0 = a; v1 = b; v2 = c;
            end else begin
               v0 = b; v1 = d; v2 = c;
            end
         end
         MODE_FAN: begin
            vc = VC_TRI;
            v2 = ctr;
            unique case (step_ff)
               3'd1: begin
                  v0 = b; v1 = d;
               end
               3'd2: begin
                  v0 = d; v1 = c;
               end
               3'd3: begin
                  v0 = c; v1 = a;
               end
               default: begin
                  v0 = a; v1 = b;
               end
            endcase
         end
         MODE_TET: begin
            vc = VC_TET;
            v0 = a;
            v3 = h;
            unique case (step_ff)
               3'd1: begin
                  v1 = d; v2 = b;
               end
               3'd2: begin
                  v1 = f; v2 = e;
               end
               3'd3: begin
                  v1 = e; v2 = g;
               end
               3'd4: begin
                  v1 = g; v2 = c;
               end
               3'd5: begin
                  v1 = c; v2 = d;
               end
               default: begin
                  v1 = b; v2 = f;
               end
            endcase
         end
         default: begin
            vc = VC_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            out_valid_ff <= busy_ff;
         end
         if (q_pop) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (fire) begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
      if (fire) begin
         rsp_status       <= cur_ff.status;
         rsp_vertex_count <= vc;
         rsp_corner_zero  <= v0;
         rsp_corner_one   <= v1;
         rsp_corner_two   <= v2;
         rsp_corner_three <= v3;
         rsp_last         <= lst;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/structured_grid_simplex_indexer_top.sv -----
// ----------------------------------------------------------------------------
// structured_grid_simplex_indexer_top
// Each transaction on the req_ side names one cell of a structured grid of
// dimension 1, 2 or 3; the rsp_ side returns the vertex indices of the
// simplices that tile it, one simplex per transaction, with rsp_last on the
// final one. 1-D gives one segment, 2-D two triangles (four around a centre
// vertex in diamond mode), 3-D the six Kuhn tetrahedra. A cell out of range
// or a 3-D diamond request returns a single error transaction with zero
// vertices. The result port passes one per cycle while drained and is the
// throughput limit. A cell crosses the front stages, the queue and the cell
// register before its first result. The user writes configuration through
// csr_ only while no cell is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module structured_grid_simplex_indexer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_data,
   // cell requests
   input  wire logic        push,
   output logic             full,
   input  wire logic [10:0] req_cell_x,
   input  wire logic [9:0]  req_cell_y,
   input  wire logic [9:0]  req_cell_z,
   // simplex results
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_vertex_count,
   output logic [30:0]      rsp_corner_zero,
   output logic [30:0]      rsp_corner_one,
   output logic [30:0]      rsp_corner_two,
   output logic [30:0]      rsp_corner_three,
   output logic             rsp_last
);
   import sgsi_pkg::*;

   // configuration registers
   logic [1:0]       dimension_ff;
   logic [DIV_W-1:0] divisions_x_ff, divisions_y_ff, divisions_z_ff;
   logic             diamond_ff;
   cfg_type          cfg;

   // front to back queue
   logic     q_push, q_full, q_pop, q_empty;
   desc_type q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff   <= DIM_TWO;
         divisions_x_ff <= DIV_W'(1);
         divisions_y_ff <= DIV_W'(1);
         divisions_z_ff <= DIV_W'(1);
         diamond_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIMENSION: begin
               dimension_ff <= csr_data[1:0];
            end
            REG_DIVISIONS_X: begin
               divisions_x_ff <= csr_data;
            end
            REG_DIVISIONS_Y: begin
               divisions_y_ff <= csr_data;
            end
            REG_DIVISIONS_Z: begin
               divisions_z_ff <= csr_data;
            end
            REG_DIAMOND: begin
               diamond_ff <= csr_data[0];
            end
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   assign cfg = '{dimension:   dimension_ff,
                  divisions_x: divisions_x_ff,
                  divisions_y: divisions_y_ff,
                  divisions_z: divisions_z_ff,
                  diamond:     diamond_ff};

   // front end: range checks, classification and base index arithmetic
   sgsi_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .in_push (push),
      .in_full (full),
      .cell_x  (req_cell_x),
      .cell_y  (req_cell_y),
      .cell_z  (req_cell_z),
      .q_push  (q_push),
      .q_data  (q_in),
      .q_full  (q_full)
   );

   // decouples the pipeline from the simplex walker
   sgsi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // back end: one simplex per cycle into the result register while it is drained
   sgsi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_data           (q_out),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_status       (rsp_status),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_corner_zero  (rsp_corner_zero),
      .rsp_corner_one   (rsp_corner_one),
      .rsp_corner_two   (rsp_corner_two),
      .rsp_corner_three (rsp_corner_three),
      .rsp_last         (rsp_last)
   );

   // an error transaction carries no vertices and closes its cell
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != ST_OK) |-> (rsp_vertex_count == VC_NONE && rsp_last))
      else $error("error transaction with vertices or without last");

   // a good transaction always carries vertices
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == ST_OK) |-> (rsp_vertex_count != VC_NONE))
      else $error("good transaction without vertices");

   // a segment is always the only simplex of its cell
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_vertex_count == VC_SEG) |-> rsp_last)
      else $error("segment not marked last");

   // the queue is never written while full
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overrun");

endmodule

`default_nettype wire
